FILE: design/nearest_segment_point_classifier_defines.svh
// Assertion macros used by the classifier top level.
`ifndef NEAREST_SEGMENT_POINT_CLASSIFIER_DEFINES_SVH
`define NEAREST_SEGMENT_POINT_CLASSIFIER_DEFINES_SVH
`ifndef SYNTH
`define NSPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define NSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);
`else
`define NSPC_ASSERT(lbl, prop, msg)
`define NSPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/nspc_pkg.sv
// Types and constants of the nearest segment point classifier.
`default_nettype none
package nspc_pkg;

    localparam int VW  = 33;   // segment and offset vector components
    localparam int PW  = 68;   // products and accumulators
    localparam int LW  = 66;   // squared segment length
    localparam int C2W = 132;  // squared cross product and root partial sums
    localparam int QW  = 31;   // distance
    localparam int TW  = 97;   // distance times squared length

    localparam logic          ACT_LOAD     = 1'b0;
    localparam logic          ACT_CLASSIFY = 1'b1;

    localparam logic [1:0]    CLS_BUILDING = 2'd0;
    localparam logic [1:0]    CLS_GROUND   = 2'd1;
    localparam logic [1:0]    CLS_NONE     = 2'd2;

    localparam logic [1:0]    REG_SEG_COUNT = 2'd0;
    localparam logic [1:0]    REG_BLD_THR   = 2'd1;
    localparam logic [1:0]    REG_GND_THR   = 2'd2;

    localparam logic [8:0]    SEG_COUNT_RST = 9'd0;
    localparam logic [30:0]   BLD_THR_RST   = 31'd262144;
    localparam logic [30:0]   GND_THR_RST   = 31'd32768;
    localparam logic [30:0]   DIST_MAX      = 31'h7FFF_FFFF;

    localparam logic [4:0]    ROOT_TOP_BIT  = 5'd30;

    // multiply sequence: one product issued per step, registered, then accumulated
    localparam logic [3:0]    MS_LEN_X  = 4'd0;
    localparam logic [3:0]    MS_LEN_Z  = 4'd1;
    localparam logic [3:0]    MS_DOT_X  = 4'd2;
    localparam logic [3:0]    MS_DOT_Z  = 4'd3;
    localparam logic [3:0]    MS_CRS_A  = 4'd4;
    localparam logic [3:0]    MS_CRS_B  = 4'd5;
    localparam logic [3:0]    MS_GAP    = 4'd6;
    localparam logic [3:0]    MS_SQ_LL  = 4'd7;
    localparam logic [3:0]    MS_SQ_HL  = 4'd8;
    localparam logic [3:0]    MS_SQ_HH  = 4'd9;
    localparam logic [3:0]    MS_LAST   = 4'd10;

    typedef struct packed {
        logic               action;
        logic [7:0]         segment_slot;
        logic signed [31:0] start_x;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_req;

    typedef struct packed {
        logic [1:0]  point_class;
        logic [7:0]  best_segment;
        logic [30:0] best_distance;
    } t_result;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_z;
    } t_seg;

    localparam int SEGW = $bits(t_seg);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LATCH,
        ST_MUL,
        ST_CHECK,
        ST_ROOT,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       start_item;
        logic       latch_seg;
        logic       mul_en;
        logic [3:0] mul_step;
        logic       root_init;
        logic       root_en;
        logic [4:0] root_bit;
        logic       upd_best;
        logic [7:0] seg_tag;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic qualify;
    } t_status;

endpackage
`default_nettype wire

FILE: design/nspc_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module nspc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/nspc_ctrl.sv
// Sequencer that walks the segment table for one classify request.
`default_nettype none
module nspc_ctrl #(
    parameter int MAX_SEGMENTS = 256,
    parameter int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    parameter int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_classify,
    input  wire logic [8:0]       i_seg_count,
    input  wire nspc_pkg::t_status i_status,
    output nspc_pkg::t_cmd        o_cmd,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    output logic                  o_busy
);

    nspc_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [3:0]       r_step, n_step;
    logic [4:0]       r_bit, n_bit;
    logic [CW-1:0]    w_clamped;
    logic             w_last;

    assign w_clamped = (32'(i_seg_count) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS) : CW'(i_seg_count);
    assign w_last    = ((r_idx + CW'(1)) == r_count);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        n_step  = r_step;
        n_bit   = r_bit;
        case (r_state)
            nspc_pkg::ST_IDLE: begin
                if (i_start && i_classify) begin
                    n_idx   = '0;
                    n_count = w_clamped;
                    n_state = (w_clamped == '0) ? nspc_pkg::ST_FINISH : nspc_pkg::ST_READ;
                end
            end
            nspc_pkg::ST_READ: begin
                n_state = nspc_pkg::ST_LATCH;
            end
            nspc_pkg::ST_LATCH: begin
                n_step  = nspc_pkg::MS_LEN_X;
                n_state = nspc_pkg::ST_MUL;
            end
            nspc_pkg::ST_MUL: begin
                n_step = r_step + 4'd1;
                if (r_step == nspc_pkg::MS_LAST) begin
                    n_state = nspc_pkg::ST_CHECK;
                end
            end
            nspc_pkg::ST_CHECK: begin
                if (i_status.qualify) begin
                    n_bit   = nspc_pkg::ROOT_TOP_BIT;
                    n_state = nspc_pkg::ST_ROOT;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = w_last ? nspc_pkg::ST_FINISH : nspc_pkg::ST_READ;
                end
            end
            nspc_pkg::ST_ROOT: begin
                n_bit = r_bit - 5'd1;
                if (r_bit == '0) begin
                    n_state = nspc_pkg::ST_UPDATE;
                end
            end
            nspc_pkg::ST_UPDATE: begin
                n_idx   = r_idx + CW'(1);
                n_state = w_last ? nspc_pkg::ST_FINISH : nspc_pkg::ST_READ;
            end
            nspc_pkg::ST_FINISH: begin
                n_state = nspc_pkg::ST_IDLE;
            end
            default: begin
                n_state = nspc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_step = r_step;
        o_cmd.root_bit = r_bit;
        o_cmd.seg_tag  = 8'(r_idx);
        o_rd_en        = 1'b0;
        o_rd_addr      = AW'(r_idx);
        o_busy         = (r_state != nspc_pkg::ST_IDLE);
        case (r_state)
            nspc_pkg::ST_IDLE:   o_cmd.start_item = i_start && i_classify;
            nspc_pkg::ST_READ:   o_rd_en          = 1'b1;
            nspc_pkg::ST_LATCH:  o_cmd.latch_seg  = 1'b1;
            nspc_pkg::ST_MUL:    o_cmd.mul_en     = 1'b1;
            nspc_pkg::ST_CHECK:  o_cmd.root_init  = i_status.qualify;
            nspc_pkg::ST_ROOT:   o_cmd.root_en    = 1'b1;
            nspc_pkg::ST_UPDATE: o_cmd.upd_best   = 1'b1;
            nspc_pkg::ST_FINISH: o_cmd.finish     = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nspc_pkg::ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_step  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_step  <= n_step;
            r_bit   <= n_bit;
        end
    end

endmodule
`default_nettype wire

FILE: design/nspc_dp.sv
// Distance datapath: shared multiplier, exact tests, bitwise root, best tracking.
`default_nettype none
module nspc_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nspc_pkg::t_req    i_req,
    input  wire nspc_pkg::t_cmd    i_cmd,
    input  wire logic [nspc_pkg::SEGW-1:0] i_seg_data,
    input  wire logic [30:0]       i_bld_thr,
    input  wire logic [30:0]       i_gnd_thr,
    output nspc_pkg::t_status      o_status,
    output logic                   o_valid,
    output nspc_pkg::t_result      o_result
);

    localparam int VW  = nspc_pkg::VW;
    localparam int PW  = nspc_pkg::PW;
    localparam int LW  = nspc_pkg::LW;
    localparam int C2W = nspc_pkg::C2W;
    localparam int QW  = nspc_pkg::QW;
    localparam int TW  = nspc_pkg::TW;

    nspc_pkg::t_seg     w_seg;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [VW-1:0] r_vx, r_vz, r_wx, r_wz;
    logic signed [33:0] w_op_a, w_op_b;
    logic signed [PW-1:0] w_prod, r_prod;
    logic [3:0]         r_dstep;
    logic               r_dval;
    logic signed [PW-1:0] r_len2, r_dot, r_c;
    logic [PW-1:0]      w_cmag;
    logic [C2W-1:0]     r_c2, w_prod_ext;
    logic [QW-1:0]      r_q;
    logic [C2W-1:0]     r_s, w_cand, w_len_ext;
    logic [TW-1:0]      r_t;
    logic [5:0]         w_bit1;
    logic               r_found;
    logic [QW-1:0]      r_best_d;
    logic [7:0]         r_best_idx;
    logic [31:0]        w_py_mag;
    logic               r_valid;
    nspc_pkg::t_result  r_result;

    assign w_seg = nspc_pkg::t_seg'(i_seg_data);

    function automatic logic signed [VW-1:0] sdiff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        sdiff = $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    assign w_cmag = r_c[PW-1] ? PW'(-r_c) : PW'(r_c);

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (i_cmd.mul_step)
            nspc_pkg::MS_LEN_X: begin
                w_op_a = $signed({r_vx[VW-1], r_vx});
                w_op_b = $signed({r_vx[VW-1], r_vx});
            end
            nspc_pkg::MS_LEN_Z: begin
                w_op_a = $signed({r_vz[VW-1], r_vz});
                w_op_b = $signed({r_vz[VW-1], r_vz});
            end
            nspc_pkg::MS_DOT_X: begin
                w_op_a = $signed({r_vx[VW-1], r_vx});
                w_op_b = $signed({r_wx[VW-1], r_wx});
            end
            nspc_pkg::MS_DOT_Z: begin
                w_op_a = $signed({r_vz[VW-1], r_vz});
                w_op_b = $signed({r_wz[VW-1], r_wz});
            end
            nspc_pkg::MS_CRS_A: begin
                w_op_a = $signed({r_vx[VW-1], r_vx});
                w_op_b = $signed({r_wz[VW-1], r_wz});
            end
            nspc_pkg::MS_CRS_B: begin
                w_op_a = $signed({r_vz[VW-1], r_vz});
                w_op_b = $signed({r_wx[VW-1], r_wx});
            end
            nspc_pkg::MS_SQ_LL: begin
                w_op_a = $signed({1'b0, w_cmag[32:0]});
                w_op_b = $signed({1'b0, w_cmag[32:0]});
            end
            nspc_pkg::MS_SQ_HL: begin
                w_op_a = $signed({2'b00, w_cmag[64:33]});
                w_op_b = $signed({1'b0, w_cmag[32:0]});
            end
            nspc_pkg::MS_SQ_HH: begin
                w_op_a = $signed({2'b00, w_cmag[64:33]});
                w_op_b = $signed({2'b00, w_cmag[64:33]});
            end
            default: begin
            end
        endcase
    end

    assign w_prod     = w_op_a * w_op_b;
    assign w_prod_ext = {{(C2W-PW){1'b0}}, r_prod};

    // q*q*L for candidate q + 2^b, built from the running q*q*L and q*L
    assign w_bit1    = {1'b0, i_cmd.root_bit} + 6'd1;
    assign w_len_ext = {{(C2W-LW){1'b0}}, r_len2[LW-1:0]};
    assign w_cand    = r_s + ({{(C2W-TW){1'b0}}, r_t} << w_bit1)
                           + (w_len_ext << {i_cmd.root_bit, 1'b0});

    assign o_status.qualify = (r_len2 != '0) && !r_dot[PW-1] && (r_dot <= r_len2);

    assign w_py_mag = r_py[31] ? 32'(-r_py) : 32'(r_py);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_item) begin
            r_px <= i_req.point_x;
            r_py <= i_req.point_y;
            r_pz <= i_req.point_z;
        end
        if (i_cmd.latch_seg) begin
            r_vx <= sdiff(w_seg.end_x, w_seg.start_x);
            r_vz <= sdiff(w_seg.end_z, w_seg.start_z);
            r_wx <= sdiff(r_px, w_seg.start_x);
            r_wz <= sdiff(r_pz, w_seg.start_z);
        end
        r_prod <= w_prod;
        if (r_dval) begin
            case (r_dstep)
                nspc_pkg::MS_LEN_X: r_len2 <= r_prod;
                nspc_pkg::MS_LEN_Z: r_len2 <= r_len2 + r_prod;
                nspc_pkg::MS_DOT_X: r_dot  <= r_prod;
                nspc_pkg::MS_DOT_Z: r_dot  <= r_dot + r_prod;
                nspc_pkg::MS_CRS_A: r_c    <= r_prod;
                nspc_pkg::MS_CRS_B: r_c    <= r_c - r_prod;
                nspc_pkg::MS_SQ_LL: r_c2   <= w_prod_ext;
                nspc_pkg::MS_SQ_HL: r_c2   <= r_c2 + (w_prod_ext << 34);
                nspc_pkg::MS_SQ_HH: r_c2   <= r_c2 + (w_prod_ext << 66);
                default: begin
                end
            endcase
        end
        if (i_cmd.root_init) begin
            r_q <= '0;
            r_s <= '0;
            r_t <= '0;
        end else if (i_cmd.root_en && (w_cand <= r_c2)) begin
            r_q <= r_q | (QW'(1) << i_cmd.root_bit);
            r_s <= w_cand;
            r_t <= r_t + ({{(TW-LW){1'b0}}, r_len2[LW-1:0]} << i_cmd.root_bit);
        end
        if (i_cmd.finish) begin
            if (r_found && (r_best_d <= i_bld_thr)) begin
                r_result.point_class  <= nspc_pkg::CLS_BUILDING;
                r_result.best_segment <= r_best_idx;
            end else begin
                r_result.point_class  <= (w_py_mag < {1'b0, i_gnd_thr}) ?
                                         nspc_pkg::CLS_GROUND : nspc_pkg::CLS_NONE;
                r_result.best_segment <= '0;
            end
            r_result.best_distance <= r_best_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dval     <= 1'b0;
            r_dstep    <= '0;
            r_found    <= 1'b0;
            r_best_d   <= nspc_pkg::DIST_MAX;
            r_best_idx <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_dval  <= i_cmd.mul_en;
            r_dstep <= i_cmd.mul_step;
            r_valid <= i_cmd.finish;
            if (i_cmd.start_item) begin
                r_found    <= 1'b0;
                r_best_d   <= nspc_pkg::DIST_MAX;
                r_best_idx <= '0;
            end else if (i_cmd.upd_best && (!r_found || (r_q < r_best_d))) begin
                // strict compare keeps the lower index on a tie
                r_found    <= 1'b1;
                r_best_d   <= r_q;
                r_best_idx <= i_cmd.seg_tag;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

FILE: design/nearest_segment_point_classifier.sv
// Top level of the nearest segment point classifier.
// A load request (action 0) writes one segment into the table in the cycle it is
// accepted and gives no result; busy stays low. A classify request (action 1)
// raises busy and walks entries 0 to segments_in_use-1 one at a time through a
// single shared 34x34 multiplier and a bit-serial distance root. Each segment
// goes through a table read, operand setup, 11 multiply steps and a range check;
// a segment whose projection lands inside it then also takes the 31-bit root
// and the best-distance update. The result is strobed on o_valid for exactly
// one cycle as busy falls; it cannot be held, so capture it then. A new
// request may be issued in that same cycle.
`default_nettype none
`include "nearest_segment_point_classifier_defines.svh"
module nearest_segment_point_classifier #(
    parameter int MAX_SEGMENTS = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire nspc_pkg::t_req    i_req,
    output logic                   o_valid,
    output nspc_pkg::t_result      o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [30:0]       i_cfg_data
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic [8:0]        r_seg_cnt;
    logic [30:0]       r_bld_thr;
    logic [30:0]       r_gnd_thr;
    nspc_pkg::t_cmd    w_cmd;
    nspc_pkg::t_status w_status;
    nspc_pkg::t_seg    w_wseg;
    logic              w_we;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [nspc_pkg::SEGW-1:0] w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_cnt <= nspc_pkg::SEG_COUNT_RST;
            r_bld_thr <= nspc_pkg::BLD_THR_RST;
            r_gnd_thr <= nspc_pkg::GND_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nspc_pkg::REG_SEG_COUNT: r_seg_cnt <= i_cfg_data[8:0];
                nspc_pkg::REG_BLD_THR:   r_bld_thr <= i_cfg_data;
                nspc_pkg::REG_GND_THR:   r_gnd_thr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // drop loads aimed past the table
    assign w_we = i_start && !o_busy && (i_req.action == nspc_pkg::ACT_LOAD)
                  && (32'(i_req.segment_slot) < MAX_SEGMENTS);

    assign w_wseg.start_x = i_req.start_x;
    assign w_wseg.start_z = i_req.start_z;
    assign w_wseg.end_x   = i_req.end_x;
    assign w_wseg.end_z   = i_req.end_z;

    nspc_ram #(
        .WIDTH (nspc_pkg::SEGW),
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_req.segment_slot)),
        .i_wdata (w_wseg),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    nspc_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_classify  (i_req.action == nspc_pkg::ACT_CLASSIFY),
        .i_seg_count (r_seg_cnt),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .o_busy      (o_busy)
    );

    nspc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (w_cmd),
        .i_seg_data (w_rdata),
        .i_bld_thr  (r_bld_thr),
        .i_gnd_thr  (r_gnd_thr),
        .o_status   (w_status),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    `NSPC_ASSERT(a_class_code, o_valid |-> (o_result.point_class != 2'd3), "bad class code")
    `NSPC_ASSERT(a_seg_zero, (o_valid && (o_result.point_class != nspc_pkg::CLS_BUILDING)) |-> (o_result.best_segment == 8'd0), "segment index outside building class")
    `NSPC_ASSERT(a_bld_thr, (o_valid && (o_result.point_class == nspc_pkg::CLS_BUILDING)) |-> (o_result.best_distance <= r_bld_thr), "building above threshold")
    `NSPC_ASSERT_NEXT(a_one_strobe, o_valid, !o_valid, "result strobe longer than one cycle")

endmodule
`default_nettype wire

FILE: tb/tb_nearest_segment_point_classifier.sv
// Self-checking testbench for the nearest segment point classifier.
`default_nettype none
module tb_nearest_segment_point_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG = 256;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    nspc_pkg::t_req      i_req;
    logic                o_valid;
    nspc_pkg::t_result   o_result;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_idx;
    logic [30:0]         i_cfg_data;

    nearest_segment_point_classifier #(.MAX_SEGMENTS(NSEG)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req(i_req), .o_valid(o_valid), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    nspc_pkg::t_seg      wall_table [NSEG];
    bit                  wall_loaded [NSEG];
    logic [8:0]          seg_count;
    logic [30:0]         bld_thr;
    logic [30:0]         gnd_thr;

    nspc_pkg::t_result   pending_class [$];
    int                  mismatches;
    int                  classify_cnt;
    int                  load_cnt;
    int                  building_cnt;
    int                  ground_cnt;
    int                  none_cnt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("timeout waiting for results");
        $display("FAILED: results differ");
        $finish;
    end

    function automatic nspc_pkg::t_result classify_point(nspc_pkg::t_req r);
        logic signed [199:0] ax, az, vx, vz, wx, wz, len2, dot, crs;
        logic [199:0]        c2, cand, q;
        logic [32:0]         ymag;
        logic [30:0]         best_d;
        logic [7:0]          best;
        bit                  found;
        int                  n;
        nspc_pkg::t_result   res;
        found  = 1'b0;
        best   = 8'd0;
        best_d = nspc_pkg::DIST_MAX;
        n = (seg_count > NSEG) ? NSEG : int'(seg_count);
        for (int i = 0; i < n; i++) begin
            ax = wall_table[i].start_x;
            az = wall_table[i].start_z;
            vx = wall_table[i].end_x;
            vz = wall_table[i].end_z;
            vx = vx - ax;
            vz = vz - az;
            if (vx == 0 && vz == 0) continue;
            wx = r.point_x;
            wz = r.point_z;
            wx = wx - ax;
            wz = wz - az;
            len2 = vx * vx + vz * vz;
            dot  = vx * wx + vz * wz;
            if (dot < 0 || dot > len2) continue;
            crs = vx * wz - vz * wx;
            c2  = crs * crs;
            q   = '0;
            for (int b = 30; b >= 0; b--) begin
                cand = q | (200'd1 << b);
                if (cand * cand * len2 <= c2) q = cand;
            end
            if (!found || q[30:0] < best_d) begin
                found  = 1'b1;
                best_d = q[30:0];
                best   = 8'(i);
            end
        end
        res.best_distance = best_d;
        if (found && best_d <= bld_thr) begin
            res.point_class  = nspc_pkg::CLS_BUILDING;
            res.best_segment = best;
        end else begin
            ymag = r.point_y[31] ? 33'(-$signed({r.point_y[31], r.point_y}))
                                 : {1'b0, r.point_y};
            res.point_class  = (ymag < {2'b00, gnd_thr}) ? nspc_pkg::CLS_GROUND
                                                        : nspc_pkg::CLS_NONE;
            res.best_segment = 8'd0;
        end
        return res;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // length of the run of loaded entries from slot 0
    function automatic int loaded_prefix();
        for (int i = 0; i < NSEG; i++)
            if (!wall_loaded[i]) return i;
        return NSEG;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return $urandom;
        if (r == 3) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    endfunction

    task automatic send_request(nspc_pkg::t_req r);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        if (r.action == nspc_pkg::ACT_LOAD) begin
            wall_table[r.segment_slot]  = '{r.start_x, r.start_z, r.end_x, r.end_z};
            wall_loaded[r.segment_slot] = 1'b1;
            load_cnt++;
        end else begin
            pending_class = {pending_class, classify_point(r)};
            classify_cnt++;
        end
    endtask

    task automatic load_wall(logic [7:0] slot, logic signed [31:0] sx, logic signed [31:0] sz,
                             logic signed [31:0] ex, logic signed [31:0] ez);
        nspc_pkg::t_req r;
        r = '{action: nspc_pkg::ACT_LOAD, segment_slot: slot, start_x: sx, start_z: sz,
              end_x: ex, end_z: ez, point_x: $urandom, point_y: $urandom, point_z: $urandom};
        send_request(r);
    endtask

    task automatic classify(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
        nspc_pkg::t_req r;
        r = '{action: nspc_pkg::ACT_CLASSIFY, segment_slot: $urandom, start_x: $urandom,
              start_z: $urandom, end_x: $urandom, end_z: $urandom,
              point_x: px, point_y: py, point_z: pz};
        send_request(r);
    endtask

    // drop start, drain all results and let the block settle before a register write
    task automatic write_reg(logic [1:0] idx, logic [30:0] data);
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_class.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nspc_pkg::REG_SEG_COUNT: seg_count = data[8:0];
            nspc_pkg::REG_BLD_THR:   bld_thr   = data;
            nspc_pkg::REG_GND_THR:   gnd_thr   = data;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        nspc_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_class.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_result);
            end else begin
                want = pending_class.pop_front();
                if (o_result.point_class !== want.point_class ||
                    o_result.best_segment !== want.best_segment ||
                    o_result.best_distance !== want.best_distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected class %0d seg %0d dist %0d, got %0d %0d %0d",
                                 want.point_class, want.best_segment, want.best_distance,
                                 o_result.point_class, o_result.best_segment,
                                 o_result.best_distance);
                end
                case (want.point_class)
                    nspc_pkg::CLS_BUILDING: building_cnt++;
                    nspc_pkg::CLS_GROUND:   ground_cnt++;
                    default:                none_cnt++;
                endcase
            end
        end
    end

    // no segments searched: ground or none on height alone
    task automatic test_empty_table();
        classify(0, 0, 0);
        classify(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        classify(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        classify(0, 32767, 0);
        classify(0, -32768, 0);
    endtask

    task automatic test_directed();
        load_wall(0, 1 << 16, 1 << 16, 1 << 16, 1 << 16);           // zero length
        load_wall(1, 0, 0, 4 << 16, 0);
        load_wall(2, 0, 0, 4 << 16, 0);                             // tie with 1
        load_wall(3, 10 << 16, -5 << 16, 10 << 16, 5 << 16);
        load_wall(4, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        load_wall(5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        load_wall(255, -3 << 16, 2 << 16, 7 << 16, -1 << 16);
        write_reg(nspc_pkg::REG_SEG_COUNT, 9'd6);
        classify(1 << 16, 0, 1 << 16);                             // on zero-length entry
        classify(1 << 16, 40000, 4 << 16);                         // exactly at threshold
        classify(1 << 16, 0, (4 << 16) + 1);                       // just beyond
        classify(0, 0, 3 << 16);                                   // start endpoint
        classify(4 << 16, 0, -2 << 16);                            // end endpoint
        classify(-1, 0, 0);                                        // projection before start
        classify(10 << 16, 0, 6 << 16);                            // projection past end
        classify(32'sh7FFF_FFFF, 0, 32'sh8000_0000);
        classify(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        write_reg(nspc_pkg::REG_SEG_COUNT, 9'd0);
        classify(2 << 16, 0, 0);
    endtask

    task automatic test_thresholds();
        write_reg(nspc_pkg::REG_SEG_COUNT, 9'd6);
        write_reg(nspc_pkg::REG_BLD_THR, 31'd0);
        write_reg(nspc_pkg::REG_GND_THR, 31'd0);
        classify(2 << 16, 0, 0);                                   // distance zero
        classify(2 << 16, 0, 1);
        write_reg(nspc_pkg::REG_BLD_THR, nspc_pkg::DIST_MAX);
        write_reg(nspc_pkg::REG_GND_THR, nspc_pkg::DIST_MAX);
        classify(20 << 16, 32'sh8000_0000, 20 << 16);
        classify(-7 << 16, 32'sh7FFF_FFFF, 3 << 16);
        classify(100 << 16, 32'sh8000_0001, 100 << 16);
        write_reg(2'd3, 31'h2AAA_AAAA);                             // unused index
        classify(5 << 16, 1, 5 << 16);
        write_reg(nspc_pkg::REG_BLD_THR, nspc_pkg::BLD_THR_RST);
        write_reg(nspc_pkg::REG_GND_THR, nspc_pkg::GND_THR_RST);
    endtask

    // fill the table, then search it whole and past its end
    task automatic test_full_table();
        for (int i = 0; i < NSEG; i++)
            load_wall(8'(i), rand_coord(), rand_coord(), rand_coord(), rand_coord());
        write_reg(nspc_pkg::REG_SEG_COUNT, 9'd256);
        classify(rand_coord(), rand_coord(), rand_coord());
        write_reg(nspc_pkg::REG_SEG_COUNT, 9'h1FF);
        classify(rand_coord(), rand_coord(), rand_coord());
        write_reg(nspc_pkg::REG_SEG_COUNT, 9'd257);
        classify(0, 0, 0);
    endtask

    task automatic test_random(int n);
        int limit;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                limit = loaded_prefix();
                write_reg(nspc_pkg::REG_SEG_COUNT,
                          9'($urandom_range(1, (limit < 16) ? limit : 16)));
                write_reg(nspc_pkg::REG_BLD_THR, $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                 : 31'($urandom_range(0, 8 << 16)));
                write_reg(nspc_pkg::REG_GND_THR, $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                 : 31'($urandom_range(0, 4 << 16)));
            end
            if ($urandom_range(0, 99) < 30)
                load_wall(8'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_coord());
            else
                classify(rand_coord(),
                         $urandom_range(0, 1) ? $urandom
                                              : $signed($urandom_range(0, 2 << 16)) - (1 << 16),
                         rand_coord());
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        mismatches = 0;
        classify_cnt = 0;
        load_cnt = 0;
        building_cnt = 0;
        ground_cnt = 0;
        none_cnt = 0;
        seg_count = nspc_pkg::SEG_COUNT_RST;
        bld_thr   = nspc_pkg::BLD_THR_RST;
        gnd_thr   = nspc_pkg::GND_THR_RST;
        for (int i = 0; i < NSEG; i++) wall_loaded[i] = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_directed();
        test_thresholds();
        test_full_table();
        test_random(300);

        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_class.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("%0d classify and %0d load requests; classes building %0d ground %0d none %0d",
                 classify_cnt, load_cnt, building_cnt, ground_cnt, none_cnt);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && pending_class.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire
